>>> hdl/multichannel_moving_average_core_defines.svh
// ----------------------------------------------------------------------------
// multichannel moving average: assertion macros
// Implication checks, sampled on the rising clock edge and off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MMA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("moving average core: check failed");

// next-cycle implication
`define MMA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("moving average core: check failed");

`else

`define MMA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MMA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Field widths shared by the moving average core and its stream interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

  localparam int SAMPLE_W  = 12;  // adc sample and ring entry width
  localparam int CHANNEL_W = 2;   // channel tag width
  localparam int AVERAGE_W = 12;  // result width

endpackage

`default_nettype wire

>>> hdl/mma_in_if.sv
// ----------------------------------------------------------------------------
// mma_in_if
// Sample stream: one adc sample with its channel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_in_if
  import mma_pkg::*;
();

  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  sample;
  logic [CHANNEL_W-1:0] channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);

endinterface

`default_nettype wire

>>> hdl/mma_out_if.sv
// ----------------------------------------------------------------------------
// mma_out_if
// Result stream: one channel average per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_out_if
  import mma_pkg::*;
();

  logic                 valid;
  logic                 ready;
  logic [AVERAGE_W-1:0] average;
  logic [CHANNEL_W-1:0] channel_out;

  modport source (output valid, output average, output channel_out, input ready);
  modport sink   (input valid, input average, input channel_out, output ready);

endinterface

`default_nettype wire

>>> hdl/multichannel_moving_average_core.sv
// pipeline: a sample transaction passes the read stage, the sum stage and the
//   output register before its result is presented
// throughput: one sample per cycle unless the result stream stalls, any channel
//   order, set by the ring ram's one read port (at accept) and write port (from the read stage)
// reset: positions and fill flags clear, sums load DEPTH * MID_VALUE; ring
//   entries read as MID_VALUE until the channel wraps, so no clearing pass
// ----------------------------------------------------------------------------
// multichannel_moving_average_core
// Boxcar moving average over the last DEPTH samples of each channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_moving_average_core_defines.svh"

module multichannel_moving_average_core
  import mma_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int DEPTH       = 16,
  parameter int SAMPLE_BITS = 12,
  parameter int MID_VALUE   = 2048
) (
  input wire logic  clk,
  input wire logic  rst,
  mma_in_if.sink    adc,
  mma_out_if.source result
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW    = CW + PW;
  localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);
  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << EFF_BITS) - 64'd1);
  localparam logic [SAMPLE_W-1:0] MID         = SAMPLE_W'(MID_VALUE);
  localparam logic [SUM_W-1:0]    SUM_RESET   = SUM_W'(DEPTH * MID_VALUE);
  localparam logic [SUM_W-1:0]    SUM_MAX     = SUM_W'(DEPTH * (2**SAMPLE_W - 1));
  localparam logic [PW-1:0]       POS_LAST    = PW'(DEPTH - 1);

  // per-channel control state
  logic [PW-1:0]       pos [CHANNELS];
  logic [CHANNELS-1:0] full;
  logic [SUM_W-1:0]    sum [CHANNELS];

  // accept side
  logic          in_acc;
  logic [CW-1:0] in_idx;
  logic          in_chv;
  logic [PW-1:0] in_pos;
  logic [AW-1:0] rd_addr;

  // read stage
  logic                 s1_valid;
  logic                 s1_adv;
  logic [SAMPLE_W-1:0]  s1_sample;
  logic [CHANNEL_W-1:0] s1_ch;
  logic [CW-1:0]        s1_idx;
  logic                 s1_chv;
  logic [AW-1:0]        s1_addr;
  logic                 s1_full;
  logic                 s1_fwd;
  logic [SAMPLE_W-1:0]  s1_fwd_data;
  logic [SAMPLE_W-1:0]  rd_data;
  logic [SAMPLE_W-1:0]  old_sample;
  logic [SUM_W-1:0]     sum_cur;
  logic [SUM_W-1:0]     sum_next;
  logic                 ram_we;

  // sum stage
  logic                 s2_valid;
  logic                 s2_adv;
  logic                 s2_free;
  logic [SUM_W-1:0]     s2_sum;
  logic [CHANNEL_W-1:0] s2_ch;
  logic [AVERAGE_W-1:0] quotient;
  logic                 out_free;

  assign in_acc  = adc.valid && adc.ready;
  assign in_idx  = CW'(adc.channel);
  assign in_chv  = 32'(adc.channel) < CHANNELS;
  assign in_pos  = in_chv ? pos[in_idx] : '0;
  assign rd_addr = {in_idx, in_pos};

  assign out_free  = !result.valid || result.ready;
  assign s2_adv    = s2_valid && out_free;
  assign s2_free   = !s2_valid || s2_adv;
  assign s1_adv    = s1_valid && s2_free;
  assign adc.ready = !s1_valid || s1_adv;

  // write position and wrap flag advance as soon as the sample is taken; the sum updates as it leaves the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos[i] <= '0;
        sum[i] <= SUM_RESET;
      end
      full <= '0;
    end else begin
      if (in_acc && in_chv) begin
        if (in_pos == POS_LAST) begin
          pos[in_idx]  <= '0;
          full[in_idx] <= 1'b1;
        end else begin
          pos[in_idx] <= in_pos + 1'b1;
        end
      end
      if (s1_adv && s1_chv) begin
        sum[s1_idx] <= sum_next;
      end
    end
  end

  mma_ring_ram #(
    .ADDR_W (AW),
    .DATA_W (SAMPLE_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_sample),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adc.ready) begin
      s1_valid <= adc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample   <= adc.sample & SAMPLE_MASK;
      s1_ch       <= adc.channel;
      s1_idx      <= in_idx;
      s1_chv      <= in_chv;
      s1_addr     <= rd_addr;
      s1_full     <= in_chv && full[in_idx];
      // entry written in this same cycle: the ram returns the stale word
      s1_fwd      <= ram_we && (s1_addr == rd_addr);
      s1_fwd_data <= s1_sample;
    end
  end

  assign ram_we = s1_adv && s1_chv;

  always_comb begin
    if (!s1_full) begin
      old_sample = MID;
    end else if (s1_fwd) begin
      old_sample = s1_fwd_data;
    end else begin
      old_sample = rd_data;
    end
    sum_cur  = s1_chv ? sum[s1_idx] : '0;
    sum_next = sum_cur - SUM_W'(old_sample) + SUM_W'(s1_sample);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_sum <= s1_chv ? sum_next : '0;
      s2_ch  <= s1_ch;
    end
  end

  mma_divide #(
    .SUM_W (SUM_W),
    .DEPTH (DEPTH)
  ) u_divide (
    .sum      (s2_sum),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      result.average     <= quotient;
      result.channel_out <= s2_ch;
    end
  end

  // unknown channel carries a zero average
  `MMA_ASSERT_IMP(a_bad_channel_zero, clk, rst,
    result.valid && (32'(result.channel_out) >= CHANNELS), result.average == '0)
  `MMA_ASSERT_NXT(a_accept_reaches_read, clk, rst, in_acc, s1_valid)
  // forwarding only occurs once the ring has wrapped
  `MMA_ASSERT_IMP(a_fwd_after_wrap, clk, rst, s1_valid && s1_fwd, s1_full)
  `MMA_ASSERT_IMP(a_sum_in_range, clk, rst, s2_valid, s2_sum <= SUM_MAX)

endmodule

`default_nettype wire

>>> hdl/mma_ring_ram.sv
// ----------------------------------------------------------------------------
// mma_ring_ram
// Simple dual-port sample ring store, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ring_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read before write on an address clash
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/mma_divide.sv
// ----------------------------------------------------------------------------
// mma_divide
// Window sum divided by the window depth, by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_divide
  import mma_pkg::*;
#(
  parameter int SUM_W = 16,
  parameter int DEPTH = 16
) (
  input  wire logic [SUM_W-1:0]     sum,
  output logic      [AVERAGE_W-1:0] quotient
);

  localparam int SHIFT  = SUM_W + $clog2(DEPTH);
  localparam int PROD_W = 2 * SUM_W + 1;
  // ceil(2^SHIFT / DEPTH) gives the exact floor quotient for any SUM_W-bit sum
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  logic [PROD_W-1:0] product;

  assign product  = PROD_W'(sum) * PROD_W'(RECIP);
  assign quotient = AVERAGE_W'(product >> SHIFT);

endmodule

`default_nettype wire
